FILE: rtl/ecid_pkg.sv
// Shared types, code constants and decode functions for the instruction decoder.
// This file has no dependencies. The front, queue, back and top modules import it.
`timescale 1ns / 1ps

package ecid_pkg;

	typedef enum logic [1:0] {
		PAGE_MAIN = 2'd0,
		PAGE_CB   = 2'd1,
		PAGE_ED   = 2'd2
	} page_t;

	typedef enum logic [1:0] {
		IDX_HL = 2'd0,
		IDX_IX = 2'd1,
		IDX_IY = 2'd2
	} idx_t;

	localparam logic [7:0] PFX_DD   = 8'hdd;
	localparam logic [7:0] PFX_FD   = 8'hfd;
	localparam logic [7:0] PFX_CB   = 8'hcb;
	localparam logic [7:0] PFX_ED   = 8'hed;
	localparam logic [7:0] OPC_HALT = 8'h76;

	localparam logic [15:0] R_A   = 16'd0;
	localparam logic [15:0] R_B   = 16'd1;
	localparam logic [15:0] R_C   = 16'd2;
	localparam logic [15:0] R_D   = 16'd3;
	localparam logic [15:0] R_E   = 16'd4;
	localparam logic [15:0] R_H   = 16'd5;
	localparam logic [15:0] R_L   = 16'd6;
	localparam logic [15:0] R_AF  = 16'd7;
	localparam logic [15:0] R_BC  = 16'd8;
	localparam logic [15:0] R_DE  = 16'd9;
	localparam logic [15:0] R_HL  = 16'd10;
	localparam logic [15:0] R_SP  = 16'd11;
	localparam logic [15:0] R_IX  = 16'd12;
	localparam logic [15:0] R_IY  = 16'd13;
	localparam logic [15:0] R_AF2 = 16'd14;
	localparam logic [15:0] R_I   = 16'd15;
	localparam logic [15:0] R_R   = 16'd16;
	localparam logic [15:0] COND_BASE = 16'd17;

	localparam logic [3:0] MD_NONE  = 4'd0;
	localparam logic [3:0] MD_REG   = 4'd1;
	localparam logic [3:0] MD_IND   = 4'd2;
	localparam logic [3:0] MD_IDX   = 4'd3;
	localparam logic [3:0] MD_COND  = 4'd4;
	localparam logic [3:0] MD_IMM8  = 4'd5;
	localparam logic [3:0] MD_IMM16 = 4'd6;
	localparam logic [3:0] MD_ADDR  = 4'd7;
	localparam logic [3:0] MD_REL   = 4'd8;
	localparam logic [3:0] MD_RST   = 4'd9;
	localparam logic [3:0] MD_LIT   = 4'd10;

	localparam logic [6:0] OP_ADC  = 7'd0;
	localparam logic [6:0] OP_ADD  = 7'd1;
	localparam logic [6:0] OP_AND  = 7'd2;
	localparam logic [6:0] OP_BIT  = 7'd3;
	localparam logic [6:0] OP_CALL = 7'd4;
	localparam logic [6:0] OP_CCF  = 7'd5;
	localparam logic [6:0] OP_CP   = 7'd6;
	localparam logic [6:0] OP_CPD  = 7'd7;
	localparam logic [6:0] OP_CPDR = 7'd8;
	localparam logic [6:0] OP_CPI  = 7'd9;
	localparam logic [6:0] OP_CPIR = 7'd10;
	localparam logic [6:0] OP_CPL  = 7'd11;
	localparam logic [6:0] OP_DAA  = 7'd12;
	localparam logic [6:0] OP_DEC  = 7'd13;
	localparam logic [6:0] OP_DI   = 7'd14;
	localparam logic [6:0] OP_DJNZ = 7'd15;
	localparam logic [6:0] OP_EI   = 7'd16;
	localparam logic [6:0] OP_EX   = 7'd17;
	localparam logic [6:0] OP_EXX  = 7'd18;
	localparam logic [6:0] OP_HALT = 7'd19;
	localparam logic [6:0] OP_IM   = 7'd20;
	localparam logic [6:0] OP_IN   = 7'd21;
	localparam logic [6:0] OP_INC  = 7'd22;
	localparam logic [6:0] OP_IND  = 7'd23;
	localparam logic [6:0] OP_INDR = 7'd24;
	localparam logic [6:0] OP_INI  = 7'd25;
	localparam logic [6:0] OP_INIR = 7'd26;
	localparam logic [6:0] OP_JP   = 7'd27;
	localparam logic [6:0] OP_JR   = 7'd28;
	localparam logic [6:0] OP_LD   = 7'd29;
	localparam logic [6:0] OP_LDD  = 7'd30;
	localparam logic [6:0] OP_LDDR = 7'd31;
	localparam logic [6:0] OP_LDI  = 7'd32;
	localparam logic [6:0] OP_LDIR = 7'd33;
	localparam logic [6:0] OP_NEG  = 7'd34;
	localparam logic [6:0] OP_NOP  = 7'd35;
	localparam logic [6:0] OP_OR   = 7'd36;
	localparam logic [6:0] OP_OUT  = 7'd37;
	localparam logic [6:0] OP_OUTD = 7'd38;
	localparam logic [6:0] OP_OTDR = 7'd39;
	localparam logic [6:0] OP_OUTI = 7'd40;
	localparam logic [6:0] OP_OTIR = 7'd41;
	localparam logic [6:0] OP_POP  = 7'd42;
	localparam logic [6:0] OP_PUSH = 7'd43;
	localparam logic [6:0] OP_RES  = 7'd44;
	localparam logic [6:0] OP_RET  = 7'd45;
	localparam logic [6:0] OP_RETI = 7'd46;
	localparam logic [6:0] OP_RETN = 7'd47;
	localparam logic [6:0] OP_RL   = 7'd48;
	localparam logic [6:0] OP_RLA  = 7'd49;
	localparam logic [6:0] OP_RLC  = 7'd50;
	localparam logic [6:0] OP_RLD  = 7'd51;
	localparam logic [6:0] OP_RLCA = 7'd52;
	localparam logic [6:0] OP_RST  = 7'd53;
	localparam logic [6:0] OP_RR   = 7'd54;
	localparam logic [6:0] OP_RRA  = 7'd55;
	localparam logic [6:0] OP_RRC  = 7'd56;
	localparam logic [6:0] OP_RRD  = 7'd57;
	localparam logic [6:0] OP_RRCA = 7'd58;
	localparam logic [6:0] OP_SBC  = 7'd59;
	localparam logic [6:0] OP_SCF  = 7'd60;
	localparam logic [6:0] OP_SET  = 7'd61;
	localparam logic [6:0] OP_SLA  = 7'd62;
	localparam logic [6:0] OP_SRA  = 7'd63;
	localparam logic [6:0] OP_SRL  = 7'd64;
	localparam logic [6:0] OP_SUB  = 7'd65;
	localparam logic [6:0] OP_XOR  = 7'd66;

	localparam logic [3:0] LEN_MAX = 4'd15;

	typedef logic [2:0][7:0] bytes_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [15:0] value;
		logic [7:0]  offset;
	} opnd_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] op;
		logic [1:0] argc;
		opnd_t      a0;
		opnd_t      a1;
		logic [1:0] cur;
	} dec_t;

	// One completed instruction as it waits between front and back.
	typedef struct packed {
		page_t      page;
		idx_t       isel;
		logic [3:0] len;
		bytes_t     bytes;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] op;
		logic [3:0] len;
		logic [1:0] argc;
		opnd_t      a0;
		opnd_t      a1;
	} result_t;

	function automatic logic [15:0] reg8_code(input logic [2:0] r);
		logic [15:0] c;
		case (r)
			3'd0: c = R_B;
			3'd1: c = R_C;
			3'd2: c = R_D;
			3'd3: c = R_E;
			3'd4: c = R_H;
			3'd5: c = R_L;
			3'd6: c = R_HL;
			default: c = R_A;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] alu_op(input logic [2:0] y);
		logic [6:0] o;
		case (y)
			3'd0: o = OP_ADD;
			3'd1: o = OP_ADC;
			3'd2: o = OP_SUB;
			3'd3: o = OP_SBC;
			3'd4: o = OP_AND;
			3'd5: o = OP_XOR;
			3'd6: o = OP_OR;
			default: o = OP_CP;
		endcase
		return o;
	endfunction

	function automatic logic [6:0] acc_op(input logic [2:0] y);
		logic [6:0] o;
		case (y)
			3'd0: o = OP_RLCA;
			3'd1: o = OP_RRCA;
			3'd2: o = OP_RLA;
			3'd3: o = OP_RRA;
			3'd4: o = OP_DAA;
			3'd5: o = OP_CPL;
			3'd6: o = OP_SCF;
			default: o = OP_CCF;
		endcase
		return o;
	endfunction

	function automatic logic [6:0] rot_op(input logic [2:0] y);
		logic [6:0] o;
		case (y)
			3'd0: o = OP_RLC;
			3'd1: o = OP_RRC;
			3'd2: o = OP_RL;
			3'd3: o = OP_RR;
			3'd4: o = OP_SLA;
			3'd5: o = OP_SRA;
			3'd7: o = OP_SRL;
			default: o = OP_ADC;
		endcase
		return o;
	endfunction

	function automatic logic [6:0] block_op(input logic [1:0] z, input logic [1:0] k);
		logic [6:0] o;
		case ({z, k})
			4'h0: o = OP_LDI;
			4'h1: o = OP_LDD;
			4'h2: o = OP_LDIR;
			4'h3: o = OP_LDDR;
			4'h4: o = OP_CPI;
			4'h5: o = OP_CPD;
			4'h6: o = OP_CPIR;
			4'h7: o = OP_CPDR;
			4'h8: o = OP_INI;
			4'h9: o = OP_IND;
			4'ha: o = OP_INIR;
			4'hb: o = OP_INDR;
			4'hc: o = OP_OUTI;
			4'hd: o = OP_OUTD;
			4'he: o = OP_OTIR;
			default: o = OP_OTDR;
		endcase
		return o;
	endfunction

	function automatic logic [15:0] ireg_code(input idx_t isel);
		logic [15:0] c;
		case (isel)
			IDX_IX: c = R_IX;
			IDX_IY: c = R_IY;
			default: c = R_HL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick(input bytes_t bs, input logic [1:0] c);
		logic [7:0] v;
		case (c)
			2'd0: v = bs[0];
			2'd1: v = bs[1];
			default: v = bs[2];
		endcase
		return v;
	endfunction

	// Appends an operand; a third one is dropped.
	function automatic dec_t put_arg(input dec_t d, input logic [3:0] m,
			input logic [15:0] v, input logic [7:0] o);
		dec_t r;
		r = d;
		if (d.argc == 2'd0) begin
			r.a0 = '{mode: m, value: v, offset: o};
			r.argc = 2'd1;
		end else if (d.argc == 2'd1) begin
			r.a1 = '{mode: m, value: v, offset: o};
			r.argc = 2'd2;
		end
		return r;
	endfunction

	function automatic dec_t take_byte(input dec_t d, input bytes_t bs, input logic [3:0] m);
		dec_t r;
		logic [7:0] v;
		v = pick(bs, d.cur);
		r = d;
		r.cur = d.cur + 2'd1;
		return put_arg(r, m, {8'd0, v}, 8'd0);
	endfunction

	function automatic dec_t take_word(input dec_t d, input bytes_t bs, input logic [3:0] m);
		dec_t r;
		logic [7:0] lo;
		logic [7:0] hi;
		lo = pick(bs, d.cur);
		hi = pick(bs, d.cur + 2'd1);
		r = d;
		r.cur = d.cur + 2'd2;
		return put_arg(r, m, {hi, lo}, 8'd0);
	endfunction

	// Eight-bit register operand; code six is (HL) or a displaced index.
	function automatic dec_t reg8(input dec_t d, input bytes_t bs, input logic [2:0] r,
			input logic [15:0] ireg);
		dec_t t;
		logic [7:0] dsp;
		t = d;
		dsp = pick(bs, d.cur);
		if (r != 3'd6) begin
			t = put_arg(t, MD_REG, reg8_code(r), 8'd0);
		end else if (ireg == R_HL) begin
			t = put_arg(t, MD_IND, R_HL, 8'd0);
		end else begin
			t.cur = d.cur + 2'd1;
			t = put_arg(t, MD_IDX, ireg, dsp);
		end
		return t;
	endfunction

	function automatic dec_t pair_ss(input dec_t d, input logic [1:0] p,
			input logic [15:0] ireg);
		logic [15:0] c;
		case (p)
			2'd0: c = R_BC;
			2'd1: c = R_DE;
			2'd2: c = ireg;
			default: c = R_SP;
		endcase
		return put_arg(d, MD_REG, c, 8'd0);
	endfunction

	function automatic dec_t pair_qq(input dec_t d, input logic [1:0] p,
			input logic [15:0] ireg);
		logic [15:0] c;
		case (p)
			2'd0: c = R_BC;
			2'd1: c = R_DE;
			2'd2: c = ireg;
			default: c = R_AF;
		endcase
		return put_arg(d, MD_REG, c, 8'd0);
	endfunction

	function automatic logic [15:0] cond_code(input logic [2:0] y);
		return COND_BASE + {13'd0, y};
	endfunction

	function automatic dec_t dec_main(input dec_t din, input bytes_t bs,
			input logic [15:0] ireg);
		dec_t d;
		logic [7:0] opc;
		logic [1:0] x;
		logic [2:0] y;
		logic [2:0] z;
		logic [1:0] p;
		logic       q;
		d = din;
		opc = bs[0];
		x = opc[7:6];
		y = opc[5:3];
		z = opc[2:0];
		p = y[2:1];
		q = y[0];
		d.cur = 2'd1;
		case (x)
			2'd0: begin
				case (z)
					3'd0: begin
						if (y == 3'd0) begin
							d.op = OP_NOP;
						end else if (y == 3'd1) begin
							d.op = OP_EX;
							d = put_arg(d, MD_REG, R_AF, 8'd0);
							d = put_arg(d, MD_REG, R_AF2, 8'd0);
						end else if (y == 3'd2) begin
							d.op = OP_DJNZ;
							d = take_byte(d, bs, MD_REL);
						end else if (y == 3'd3) begin
							d.op = OP_JR;
							d = take_byte(d, bs, MD_REL);
						end else begin
							d.op = OP_JR;
							d = put_arg(d, MD_COND, cond_code({1'b0, y[1:0]}), 8'd0);
							d = take_byte(d, bs, MD_REL);
						end
					end
					3'd1: begin
						if (!q) begin
							d.op = OP_LD;
							d = pair_ss(d, p, ireg);
							d = take_word(d, bs, MD_IMM16);
						end else begin
							d.op = OP_ADD;
							d = put_arg(d, MD_REG, ireg, 8'd0);
							d = pair_ss(d, p, ireg);
						end
					end
					3'd2: begin
						d.op = OP_LD;
						case (y)
							3'd0: begin
								d = put_arg(d, MD_IND, R_BC, 8'd0);
								d = put_arg(d, MD_REG, R_A, 8'd0);
							end
							3'd1: begin
								d = put_arg(d, MD_REG, R_A, 8'd0);
								d = put_arg(d, MD_IND, R_BC, 8'd0);
							end
							3'd2: begin
								d = put_arg(d, MD_IND, R_DE, 8'd0);
								d = put_arg(d, MD_REG, R_A, 8'd0);
							end
							3'd3: begin
								d = put_arg(d, MD_REG, R_A, 8'd0);
								d = put_arg(d, MD_IND, R_DE, 8'd0);
							end
							3'd4: begin
								d = take_word(d, bs, MD_ADDR);
								d = put_arg(d, MD_REG, ireg, 8'd0);
							end
							3'd5: begin
								d = put_arg(d, MD_REG, ireg, 8'd0);
								d = take_word(d, bs, MD_ADDR);
							end
							3'd6: begin
								d = take_word(d, bs, MD_ADDR);
								d = put_arg(d, MD_REG, R_A, 8'd0);
							end
							default: begin
								d = put_arg(d, MD_REG, R_A, 8'd0);
								d = take_word(d, bs, MD_ADDR);
							end
						endcase
					end
					3'd3: begin
						d.op = q ? OP_DEC : OP_INC;
						d = pair_ss(d, p, ireg);
					end
					3'd4: begin
						d.op = OP_INC;
						d = reg8(d, bs, y, ireg);
					end
					3'd5: begin
						d.op = OP_DEC;
						d = reg8(d, bs, y, ireg);
					end
					3'd6: begin
						d.op = OP_LD;
						d = reg8(d, bs, y, ireg);
						d = take_byte(d, bs, MD_IMM8);
					end
					default: d.op = acc_op(y);
				endcase
			end
			2'd1: begin
				if (opc == OPC_HALT) begin
					d.op = OP_HALT;
				end else begin
					d.op = OP_LD;
					d = reg8(d, bs, y, ireg);
					d = reg8(d, bs, z, ireg);
				end
			end
			2'd2: begin
				d.op = alu_op(y);
				if (y == 3'd0 || y == 3'd1 || y == 3'd3) begin
					d = put_arg(d, MD_REG, R_A, 8'd0);
				end
				d = reg8(d, bs, z, ireg);
			end
			default: begin
				case (z)
					3'd0: begin
						d.op = OP_RET;
						d = put_arg(d, MD_COND, cond_code(y), 8'd0);
					end
					3'd1: begin
						if (!q) begin
							d.op = OP_POP;
							d = pair_qq(d, p, ireg);
						end else if (p == 2'd0) begin
							d.op = OP_RET;
						end else if (p == 2'd1) begin
							d.op = OP_EXX;
						end else if (p == 2'd2) begin
							d.op = OP_JP;
							d = put_arg(d, MD_IND, ireg, 8'd0);
						end else begin
							d.op = OP_LD;
							d = put_arg(d, MD_REG, R_SP, 8'd0);
							d = put_arg(d, MD_REG, ireg, 8'd0);
						end
					end
					3'd2: begin
						d.op = OP_JP;
						d = put_arg(d, MD_COND, cond_code(y), 8'd0);
						d = take_word(d, bs, MD_IMM16);
					end
					3'd3: begin
						case (y)
							3'd0: begin
								d.op = OP_JP;
								d = take_word(d, bs, MD_IMM16);
							end
							3'd2: begin
								d.op = OP_OUT;
								d = take_byte(d, bs, MD_IMM8);
								d = put_arg(d, MD_REG, R_A, 8'd0);
							end
							3'd3: begin
								d.op = OP_IN;
								d = put_arg(d, MD_REG, R_A, 8'd0);
								d = take_byte(d, bs, MD_IMM8);
							end
							3'd4: begin
								d.op = OP_EX;
								d = put_arg(d, MD_IND, R_SP, 8'd0);
								d = put_arg(d, MD_REG, ireg, 8'd0);
							end
							3'd5: begin
								d.op = OP_EX;
								d = put_arg(d, MD_REG, R_DE, 8'd0);
								d = put_arg(d, MD_REG, R_HL, 8'd0);
							end
							3'd6: d.op = OP_DI;
							3'd7: d.op = OP_EI;
							default: d.ok = 1'b0;
						endcase
					end
					3'd4: begin
						d.op = OP_CALL;
						d = put_arg(d, MD_COND, cond_code(y), 8'd0);
						d = take_word(d, bs, MD_IMM16);
					end
					3'd5: begin
						if (!q) begin
							d.op = OP_PUSH;
							d = pair_qq(d, p, ireg);
						end else if (p == 2'd0) begin
							d.op = OP_CALL;
							d = take_word(d, bs, MD_IMM16);
						end else begin
							d.ok = 1'b0;
						end
					end
					3'd6: begin
						d.op = alu_op(y);
						if (y == 3'd0 || y == 3'd1 || y == 3'd3) begin
							d = put_arg(d, MD_REG, R_A, 8'd0);
						end
						d = take_byte(d, bs, MD_IMM8);
					end
					default: begin
						d.op = OP_RST;
						d = put_arg(d, MD_RST, {10'd0, y, 3'b000}, 8'd0);
					end
				endcase
			end
		endcase
		return d;
	endfunction

	function automatic dec_t dec_cb(input dec_t din, input bytes_t bs,
			input logic [15:0] ireg);
		dec_t d;
		logic       ix;
		logic [7:0] opc;
		logic [1:0] x;
		logic [2:0] y;
		d = din;
		ix = (ireg != R_HL);
		opc = ix ? bs[1] : bs[0];
		x = opc[7:6];
		y = opc[5:3];
		d.cur = ix ? 2'd2 : 2'd1;
		if (x == 2'd0 && y == 3'd6) begin
			d.ok = 1'b0;
		end else begin
			if (x == 2'd0) begin
				d.op = rot_op(y);
			end else begin
				d.op = (x == 2'd1) ? OP_BIT : ((x == 2'd2) ? OP_RES : OP_SET);
				d = put_arg(d, MD_LIT, {13'd0, y}, 8'd0);
			end
			if (ix) begin
				d = put_arg(d, MD_IDX, ireg, bs[0]);
			end else begin
				d = reg8(d, bs, opc[2:0], R_HL);
			end
		end
		return d;
	endfunction

	function automatic dec_t dec_ed(input dec_t din, input bytes_t bs);
		dec_t d;
		logic [7:0] opc;
		logic [1:0] x;
		logic [2:0] y;
		logic [2:0] z;
		logic [1:0] p;
		logic       q;
		d = din;
		opc = bs[0];
		x = opc[7:6];
		y = opc[5:3];
		z = opc[2:0];
		p = y[2:1];
		q = y[0];
		d.cur = 2'd1;
		if (x == 2'd1) begin
			case (z)
				3'd0: begin
					if (y == 3'd6) begin
						d.ok = 1'b0;
					end else begin
						d.op = OP_IN;
						d = reg8(d, bs, y, R_HL);
						d = put_arg(d, MD_IND, R_C, 8'd0);
					end
				end
				3'd1: begin
					if (y == 3'd6) begin
						d.ok = 1'b0;
					end else begin
						d.op = OP_OUT;
						d = put_arg(d, MD_IND, R_C, 8'd0);
						d = reg8(d, bs, y, R_HL);
					end
				end
				3'd2: begin
					d.op = q ? OP_ADC : OP_SBC;
					d = put_arg(d, MD_REG, R_HL, 8'd0);
					d = pair_ss(d, p, R_HL);
				end
				3'd3: begin
					d.op = OP_LD;
					if (!q) begin
						d = take_word(d, bs, MD_ADDR);
						d = pair_ss(d, p, R_HL);
					end else begin
						d = pair_ss(d, p, R_HL);
						d = take_word(d, bs, MD_ADDR);
					end
				end
				3'd4: begin
					if (y == 3'd0) d.op = OP_NEG;
					else d.ok = 1'b0;
				end
				3'd5: begin
					if (y == 3'd0) d.op = OP_RETN;
					else if (y == 3'd1) d.op = OP_RETI;
					else d.ok = 1'b0;
				end
				3'd6: begin
					d.op = OP_IM;
					if (y == 3'd0) d = put_arg(d, MD_LIT, 16'd0, 8'd0);
					else if (y == 3'd2) d = put_arg(d, MD_LIT, 16'd1, 8'd0);
					else if (y == 3'd3) d = put_arg(d, MD_LIT, 16'd2, 8'd0);
					else d.ok = 1'b0;
				end
				default: begin
					case (y)
						3'd0: begin
							d.op = OP_LD;
							d = put_arg(d, MD_REG, R_I, 8'd0);
							d = put_arg(d, MD_REG, R_A, 8'd0);
						end
						3'd1: begin
							d.op = OP_LD;
							d = put_arg(d, MD_REG, R_R, 8'd0);
							d = put_arg(d, MD_REG, R_A, 8'd0);
						end
						3'd2: begin
							d.op = OP_LD;
							d = put_arg(d, MD_REG, R_A, 8'd0);
							d = put_arg(d, MD_REG, R_I, 8'd0);
						end
						3'd3: begin
							d.op = OP_LD;
							d = put_arg(d, MD_REG, R_A, 8'd0);
							d = put_arg(d, MD_REG, R_R, 8'd0);
						end
						3'd4: d.op = OP_RRD;
						3'd5: d.op = OP_RLD;
						default: d.ok = 1'b0;
					endcase
				end
			endcase
		end else if (x == 2'd2 && !z[2] && y[2]) begin
			d.op = block_op(z[1:0], y[1:0]);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	// Full decode of one instruction; undefined encodings come back cleared.
	function automatic dec_t decode(input page_t page, input idx_t isel, input bytes_t bs);
		dec_t d;
		d = '0;
		d.ok = 1'b1;
		case (page)
			PAGE_CB: d = dec_cb(d, bs, ireg_code(isel));
			PAGE_ED: d = dec_ed(d, bs);
			default: d = dec_main(d, bs, ireg_code(isel));
		endcase
		if (!d.ok) begin
			d.op = OP_ADC;
			d.argc = 2'd0;
			d.a0 = '0;
			d.a1 = '0;
		end
		return d;
	endfunction

endpackage

FILE: rtl/ecid_front.sv
// Front end: takes code bytes, tracks prefixes and gathers instruction bytes.
// Depends on ecid_pkg; pushes finished instructions into ecid_queue.
`timescale 1ns / 1ps

module ecid_front import ecid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] code_byte,
	output logic       push,
	output entry_t     entry
);

	idx_t       isel_q;
	page_t      page_q;
	logic [3:0] plen_q;
	logic [1:0] pos_q;
	bytes_t     held_q;

	bytes_t     cur_bytes;
	logic       is_prefix;
	dec_t       probe;
	logic [2:0] next_pos;
	logic [4:0] len_sum;

	always_comb begin
		cur_bytes = held_q;
		cur_bytes[pos_q] = code_byte;
		is_prefix = (page_q == PAGE_MAIN) && (pos_q == 2'd0) &&
			(code_byte inside {PFX_DD, PFX_FD, PFX_CB, PFX_ED});
		// Only the byte count of the probe matters here; it depends only on the prefix state and the opcode.
		probe = decode(page_q, isel_q, cur_bytes);
		next_pos = {1'b0, pos_q} + 3'd1;
		len_sum = {1'b0, plen_q} + {3'd0, probe.cur};
		push = take && !is_prefix && (next_pos >= {1'b0, probe.cur});
		entry.page = page_q;
		entry.isel = isel_q;
		entry.len = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[3:0];
		entry.bytes = cur_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isel_q <= IDX_HL;
			page_q <= PAGE_MAIN;
			plen_q <= 4'd0;
			pos_q <= 2'd0;
		end else if (take) begin
			if (is_prefix) begin
				case (code_byte)
					PFX_DD: isel_q <= IDX_IX;
					PFX_FD: isel_q <= IDX_IY;
					PFX_CB: page_q <= PAGE_CB;
					default: page_q <= PAGE_ED;
				endcase
				if (plen_q != LEN_MAX) plen_q <= plen_q + 4'd1;
			end else if (push) begin
				isel_q <= IDX_HL;
				page_q <= PAGE_MAIN;
				plen_q <= 4'd0;
				pos_q <= 2'd0;
			end else begin
				pos_q <= next_pos[1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_prefix) begin
			held_q[pos_q] <= code_byte;
		end
	end

endmodule

FILE: rtl/ecid_queue.sv
// Two-entry queue of gathered instructions between the front and back ends.
// Depends on ecid_pkg for the entry type.
`timescale 1ns / 1ps

module ecid_queue import ecid_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output entry_t rd_entry,
	output logic   full,
	output logic   not_empty
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && cnt_q == 2'd1) |=> full) else $error("queue count lost a write");
	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers disagree");

endmodule

FILE: rtl/ecid_back.sv
// Back end: decodes the oldest queued instruction into the output register.
// Depends on ecid_pkg for the decode function and result type.
`timescale 1ns / 1ps

module ecid_back import ecid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    avail,
	input  entry_t  entry,
	input  logic    out_stall,
	output logic    pop,
	output logic    out_valid,
	output result_t res
);

	logic    out_valid_q;
	result_t res_q;
	dec_t    dec;

	assign out_valid = out_valid_q;
	assign res = res_q;
	assign pop = avail && (!out_valid_q || !out_stall);

	always_comb begin
		dec = decode(entry.page, entry.isel, entry.bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.ok <= dec.ok;
			res_q.op <= dec.op;
			res_q.len <= entry.len;
			res_q.argc <= dec.argc;
			res_q.a0 <= dec.a0;
			res_q.a1 <= dec.a1;
		end
	end

endmodule

FILE: rtl/eight_bit_cpu_instruction_decoder.sv
// Top level of the streaming instruction decoder.
// Depends on ecid_pkg and instantiates ecid_front, ecid_queue and ecid_back.
`timescale 1ns / 1ps

// The input channel (in_valid, in_stall, code_byte) moves one program byte per transfer.
// Prefix bytes only update the held prefix state; the byte that completes an instruction
// produces exactly one transfer on the output channel (out_valid, out_stall and the
// decoded fields). Undefined encodings come out with decode_ok low.
// Throughput is one byte per cycle while the queue is not full. A completed instruction is
// written into the queue at the edge that transfers its last byte, then is decoded from the
// queue into the output register once that register is free, and out_valid rises as the
// result is registered; the result then transfers when out_stall is low.
// When the receiver holds out_stall, the result register holds still and up to two more
// instructions collect in the queue; in_stall rises only when that queue is full, so the
// input side keeps moving while a result is waiting.
// Reset clears the prefix state, the queue and the output valid flag; nothing needs to be
// swept, and bytes are accepted as soon as reset is released.

module eight_bit_cpu_instruction_decoder import ecid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        decode_ok,
	output logic [6:0]  operation,
	output logic [3:0]  length_bytes,
	output logic [1:0]  arg_count,
	output logic [3:0]  first_mode,
	output logic [15:0] first_value,
	output logic [7:0]  first_offset,
	output logic [3:0]  second_mode,
	output logic [15:0] second_value,
	output logic [7:0]  second_offset
);

	logic    take;
	logic    push;
	logic    pop;
	logic    full;
	logic    avail;
	entry_t  wr_entry;
	entry_t  rd_entry;
	result_t res;

	// The input transfer happens whenever in_valid is high and the queue has room.
	assign in_stall = full;
	assign take = in_valid && !full;

	ecid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.code_byte (code_byte),
		.push      (push),
		.entry     (wr_entry)
	);

	ecid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.full      (full),
		.not_empty (avail)
	);

	ecid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.entry     (rd_entry),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.res       (res)
	);

	assign decode_ok     = res.ok;
	assign operation     = res.op;
	assign length_bytes  = res.len;
	assign arg_count     = res.argc;
	assign first_mode    = res.a0.mode;
	assign first_value   = res.a0.value;
	assign first_offset  = res.a0.offset;
	assign second_mode   = res.a1.mode;
	assign second_value  = res.a1.value;
	assign second_offset = res.a1.offset;

endmodule
